// ===== src/epc_pkg.sv =====
// ----------------------------------------------------------------------------
// epc_pkg
// Widths, stage counts and the pipeline word shared by the edge/plane block.
// ----------------------------------------------------------------------------
package epc_pkg;

    localparam int FRONT_STAGES = 3;
    localparam int DIV_STEPS    = 33;
    localparam int NORM_BITS    = 15;
    localparam int NUM_STAGES   = FRONT_STAGES + DIV_STEPS;

    typedef struct packed {
        logic               hit;
        logic               sgn_x;
        logic               sgn_y;
        logic               neg_nx;
        logic               neg_ny;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic [31:0]        dxm;
        logic [31:0]        dym;
        logic [32:0]        num;
        logic [32:0]        den;
        logic [16:0]        sxm;
        logic [16:0]        sym;
        logic [47:0]        pxl;
        logic [48:0]        pxh;
        logic [47:0]        pyl;
        logic [48:0]        pyh;
        logic [33:0]        csx;
        logic [33:0]        csy;
        logic [32:0]        rem_x;
        logic [32:0]        rem_y;
        logic [32:0]        lo_x;
        logic [32:0]        lo_y;
        logic [32:0]        q_x;
        logic [32:0]        q_y;
        logic [33:0]        len2;
        logic [65:0]        t_x;
        logic [65:0]        t_y;
        logic [65:0]        p_x;
        logic [65:0]        p_y;
        logic [65:0]        acc_x;
        logic [65:0]        acc_y;
        logic [NORM_BITS-1:0] m_x;
        logic [NORM_BITS-1:0] m_y;
    } t_pipe;

endpackage

// ===== src/edge_plane_crossing_top.sv =====
// ----------------------------------------------------------------------------
// edge_plane_crossing_top
// Crossing point of a terrain edge with a horizontal plane, plus the unit
// horizontal normal of the summed endpoint normals.
// ----------------------------------------------------------------------------
//  channel   | handshake            | payload
//  ----------+----------------------+-------------------------------------
//  input     | i_valid / o_stall    | i_a_*, i_b_* endpoint fields
//  result    | o_valid / i_stall    | o_hit, o_cross_x/y, o_norm_x/y
//  config    | i_cfg_we             | i_cfg_wdata (plane height)
//
// one request per cycle while o_stall is low; 3 front stages, 33 divider
// stages that also hold the 16-step normal search, one output register
// every stage has its own valid bit; a stage loads when it is empty or the
// stage after it moves, so bubbles are squeezed out under output stall
// reset (synchronous, active low) clears all valid bits and the plane height
module edge_plane_crossing_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic signed [31:0]  i_cfg_wdata,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic signed [31:0]  i_a_x,
    input  logic signed [31:0]  i_a_y,
    input  logic signed [31:0]  i_a_z,
    input  logic signed [15:0]  i_a_nx,
    input  logic signed [15:0]  i_a_ny,
    input  logic signed [31:0]  i_b_x,
    input  logic signed [31:0]  i_b_y,
    input  logic signed [31:0]  i_b_z,
    input  logic signed [15:0]  i_b_nx,
    input  logic signed [15:0]  i_b_ny,
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_hit,
    output logic signed [31:0]  o_cross_x,
    output logic signed [31:0]  o_cross_y,
    output logic signed [15:0]  o_norm_x,
    output logic signed [15:0]  o_norm_y
);
    import epc_pkg::*;

    logic signed [31:0] r_height;
    t_pipe              r_pipe [NUM_STAGES];
    t_pipe              n_pipe [NUM_STAGES];
    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] en;
    logic               en_out;

    logic               r_ovld;
    logic               r_hit;
    logic signed [31:0] r_cx;
    logic signed [31:0] r_cy;
    logic signed [15:0] r_nx;
    logic signed [15:0] r_ny;
    logic               n_hit;
    logic signed [31:0] n_cx;
    logic signed [31:0] n_cy;
    logic signed [15:0] n_nx;
    logic signed [15:0] n_ny;

    // load enables, back to front
    always_comb begin
        en_out = !r_ovld || !i_stall;
        en[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || en_out;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_stall = !en[0];

    always_comb begin
        logic signed [32:0] dz, hz, dx, dy;
        logic signed [16:0] sx, sy;
        logic [33:0]        tr_x, tr_y;
        logic [65:0]        cp_x, cp_y;
        logic               ok_x, ok_y;
        logic [67:0]        lhs_x, lhs_y, rhs_x, rhs_y;
        logic signed [33:0] cx, cy;
        logic signed [15:0] nx, ny;
        t_pipe              s;
        int                 st;
        int                 kb;

        for (int k = 0; k < NUM_STAGES; k++) begin
            n_pipe[k] = r_pipe[k];
        end

        // stage 0: differences and magnitudes
        s = r_pipe[0];
        dz = 33'(i_a_z) - 33'(i_b_z);
        hz = 33'(r_height) - 33'(i_b_z);
        dx = 33'(i_a_x) - 33'(i_b_x);
        dy = 33'(i_a_y) - 33'(i_b_y);
        sx = 17'(i_a_nx) + 17'(i_b_nx);
        sy = 17'(i_a_ny) + 17'(i_b_ny);
        s.hit = !((r_height > i_a_z && r_height > i_b_z) ||
                  (r_height < i_a_z && r_height < i_b_z)) && (i_a_z != i_b_z);
        s.den   = dz[32] ? 33'(-dz) : 33'(dz);
        s.num   = hz[32] ? 33'(-hz) : 33'(hz);
        s.sgn_x = dx[32];
        s.sgn_y = dy[32];
        s.dxm   = dx[32] ? 32'(-dx) : 32'(dx);
        s.dym   = dy[32] ? 32'(-dy) : 32'(dy);
        s.neg_nx = sx[16];
        s.neg_ny = sy[16];
        s.sxm   = sx[16] ? 17'(-sx) : 17'(sx);
        s.sym   = sy[16] ? 17'(-sy) : 17'(sy);
        s.bx    = i_b_x;
        s.by    = i_b_y;
        n_pipe[0] = s;

        // stage 1: split products and squares
        s = r_pipe[0];
        s.pxl = 48'(s.dxm) * 48'(s.num[15:0]);
        s.pxh = 49'(s.dxm) * 49'(s.num[32:16]);
        s.pyl = 48'(s.dym) * 48'(s.num[15:0]);
        s.pyh = 49'(s.dym) * 49'(s.num[32:16]);
        s.csx = 34'(s.sxm) * 34'(s.sxm);
        s.csy = 34'(s.sym) * 34'(s.sym);
        n_pipe[1] = s;

        // stage 2: rounded dividend, length squared, search targets
        s = r_pipe[1];
        cp_x = 66'(s.pxl) + (66'(s.pxh) << 16) + 66'(s.den >> 1);
        cp_y = 66'(s.pyl) + (66'(s.pyh) << 16) + 66'(s.den >> 1);
        s.rem_x = cp_x[65:33];
        s.lo_x  = cp_x[32:0];
        s.rem_y = cp_y[65:33];
        s.lo_y  = cp_y[32:0];
        s.q_x   = '0;
        s.q_y   = '0;
        s.len2  = s.csx + s.csy;
        s.t_x   = 66'(s.csx) << 28;
        s.t_y   = 66'(s.csy) << 28;
        s.p_x   = '0;
        s.p_y   = '0;
        s.acc_x = '0;
        s.acc_y = '0;
        s.m_x   = '0;
        s.m_y   = '0;
        n_pipe[2] = s;

        // divider stages, normal search rides along in the first sixteen
        for (int k = FRONT_STAGES; k < NUM_STAGES; k++) begin
            s  = r_pipe[k-1];
            st = k - FRONT_STAGES;

            tr_x = {s.rem_x, s.lo_x[32]};
            tr_y = {s.rem_y, s.lo_y[32]};
            ok_x = tr_x >= {1'b0, s.den};
            ok_y = tr_y >= {1'b0, s.den};
            s.rem_x = ok_x ? 33'(tr_x - {1'b0, s.den}) : tr_x[32:0];
            s.rem_y = ok_y ? 33'(tr_y - {1'b0, s.den}) : tr_y[32:0];
            s.lo_x  = s.lo_x << 1;
            s.lo_y  = s.lo_y << 1;
            s.q_x   = {s.q_x[31:0], ok_x};
            s.q_y   = {s.q_y[31:0], ok_y};

            if (st < NORM_BITS) begin
                // candidate m + 2^kb: P + 2^(kb+1)*Q + 4^kb*L against target
                kb = NORM_BITS - 1 - st;
                cp_x = s.p_x + (s.acc_x << (kb + 1)) + (66'(s.len2) << (2 * kb));
                cp_y = s.p_y + (s.acc_y << (kb + 1)) + (66'(s.len2) << (2 * kb));
                ok_x = !s.m_x[NORM_BITS-1] && (cp_x <= s.t_x);
                ok_y = !s.m_y[NORM_BITS-1] && (cp_y <= s.t_y);
                if (ok_x) begin
                    s.p_x   = cp_x;
                    s.acc_x = s.acc_x + (66'(s.len2) << kb);
                    s.m_x   = s.m_x | NORM_BITS'(1 << kb);
                end
                if (ok_y) begin
                    s.p_y   = cp_y;
                    s.acc_y = s.acc_y + (66'(s.len2) << kb);
                    s.m_y   = s.m_y | NORM_BITS'(1 << kb);
                end
            end else if (st == NORM_BITS) begin
                // round to nearest: (2m+1)^2 L <= 4T
                lhs_x = (68'(s.p_x) << 2) + (68'(s.acc_x) << 2) + 68'(s.len2);
                lhs_y = (68'(s.p_y) << 2) + (68'(s.acc_y) << 2) + 68'(s.len2);
                rhs_x = 68'(s.t_x) << 2;
                rhs_y = 68'(s.t_y) << 2;
                if (!s.m_x[NORM_BITS-1] && lhs_x <= rhs_x) begin
                    s.m_x = s.m_x + NORM_BITS'(1);
                end
                if (!s.m_y[NORM_BITS-1] && lhs_y <= rhs_y) begin
                    s.m_y = s.m_y + NORM_BITS'(1);
                end
            end
            n_pipe[k] = s;
        end

        // output assembly
        s  = r_pipe[NUM_STAGES-1];
        cx = s.sgn_x ? 34'(s.bx) - $signed({1'b0, s.q_x})
                     : 34'(s.bx) + $signed({1'b0, s.q_x});
        cy = s.sgn_y ? 34'(s.by) - $signed({1'b0, s.q_y})
                     : 34'(s.by) + $signed({1'b0, s.q_y});
        nx = s.neg_nx ? -$signed(16'({1'b0, s.m_x})) : $signed(16'({1'b0, s.m_x}));
        ny = s.neg_ny ? -$signed(16'({1'b0, s.m_y})) : $signed(16'({1'b0, s.m_y}));
        n_hit = s.hit;
        n_cx  = s.hit ? cx[31:0] : '0;
        n_cy  = s.hit ? cy[31:0] : '0;
        n_nx  = (s.hit && s.len2 != '0) ? nx : '0;
        n_ny  = (s.hit && s.len2 != '0) ? ny : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height <= '0;
            r_vld    <= '0;
            r_ovld   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_height <= i_cfg_wdata;
            end
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
            if (en_out) begin
                r_ovld <= r_vld[NUM_STAGES-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NUM_STAGES; k++) begin
            if (en[k]) begin
                r_pipe[k] <= n_pipe[k];
            end
        end
        if (en_out) begin
            r_hit <= n_hit;
            r_cx  <= n_cx;
            r_cy  <= n_cy;
            r_nx  <= n_nx;
            r_ny  <= n_ny;
        end
    end

    assign o_valid   = r_ovld;
    assign o_hit     = r_hit;
    assign o_cross_x = r_cx;
    assign o_cross_y = r_cy;
    assign o_norm_x  = r_nx;
    assign o_norm_y  = r_ny;

endmodule

// ===== tb/edge_plane_crossing_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// edge_plane_crossing_top_tb
// Drives terrain edges through the crossing block under several plane heights,
// predicts hit, crossing point and unit normal for each, and checks every
// result in order, with both channels idling at random until the last, quiet pass.
// ----------------------------------------------------------------------------
module edge_plane_crossing_top_tb;

    localparam int LATENCY     = 37;
    localparam int STALL_LIMIT = 4000;

    typedef struct {
        logic signed [31:0] a_x, a_y, a_z, b_x, b_y, b_z;
        logic signed [15:0] a_nx, a_ny, b_nx, b_ny;
    } t_edge;

    typedef struct {
        logic               hit;
        logic signed [31:0] cross_x, cross_y;
        logic signed [15:0] norm_x, norm_y;
    } t_cross;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic signed [31:0] i_cfg_wdata = '0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic signed [31:0] i_a_x = '0, i_a_y = '0, i_a_z = '0;
    logic signed [15:0] i_a_nx = '0, i_a_ny = '0;
    logic signed [31:0] i_b_x = '0, i_b_y = '0, i_b_z = '0;
    logic signed [15:0] i_b_nx = '0, i_b_ny = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic               o_hit;
    logic signed [31:0] o_cross_x, o_cross_y;
    logic signed [15:0] o_norm_x, o_norm_y;

    edge_plane_crossing_top i_dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    logic signed [31:0] plane_h = '0;
    t_cross             pending_q[$];
    int                 n_fail = 0;
    int                 n_sent = 0;
    int                 n_hits = 0;
    int                 n_checked = 0;
    int                 idle_cycles = 0;
    bit                 quiet = 1'b0;

    function automatic logic signed [63:0] lerp(logic signed [63:0] a, logic signed [63:0] b,
                                                logic [63:0] num, logic [63:0] den);
        logic signed [63:0] d;
        logic [63:0]        q;
        d = a - b;
        q = ((d < 0 ? -d : d) * num + den / 2) / den;
        return d < 0 ? b - q : b + q;
    endfunction

    function automatic logic signed [15:0] unit_part(logic signed [63:0] c, logic [63:0] len2);
        logic [63:0] cm, tgt, m, cand, t;
        cm  = c < 0 ? -c : c;
        tgt = cm * cm * (64'd1 << 28);
        m   = 0;
        for (int b = 14; b >= 0; b--) begin
            cand = m + (64'd1 << b);
            if (cand <= 16384 && cand * cand * len2 <= tgt) m = cand;
        end
        if (m < 16384) begin
            t = 2 * m + 1;
            if (t * t * len2 <= tgt * 4) m++;
        end
        return c < 0 ? -m[15:0] : m[15:0];
    endfunction

    function automatic t_cross cross_of(t_edge e);
        t_cross             r;
        logic signed [63:0] h, az, bz, sx, sy;
        logic [63:0]        num, den, len2;
        h  = 64'(plane_h);
        az = 64'(e.a_z);
        bz = 64'(e.b_z);
        r  = '{default: '0};
        r.hit = !((h > az && h > bz) || (h < az && h < bz)) && az != bz;
        if (r.hit) begin
            den = az > bz ? az - bz : bz - az;
            num = h > bz ? h - bz : bz - h;
            r.cross_x = 32'(lerp(64'(e.a_x), 64'(e.b_x), num, den));
            r.cross_y = 32'(lerp(64'(e.a_y), 64'(e.b_y), num, den));
            sx = 64'(e.a_nx) + 64'(e.b_nx);
            sy = 64'(e.a_ny) + 64'(e.b_ny);
            len2 = sx * sx + sy * sy;
            if (len2 != 0) begin
                r.norm_x = unit_part(sx, len2);
                r.norm_y = unit_part(sy, len2);
            end
        end
        return r;
    endfunction

    // result side: random stall bursts, in-order compare
    initial begin
        int n;
        forever begin
            @(posedge i_clk);
            if (!quiet && $urandom_range(0, 9) == 0) begin
                n = $urandom_range(1, 8);
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_cross e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_q.size() == 0) begin
                $display("%0t: result with no request outstanding", $time);
                n_fail++;
            end else begin
                e = pending_q.pop_front();
                n_checked++;
                if (o_hit !== e.hit || o_cross_x !== e.cross_x || o_cross_y !== e.cross_y ||
                    o_norm_x !== e.norm_x || o_norm_y !== e.norm_y) begin
                    $display("%0t: mismatch exp hit=%0d x=%0d y=%0d nx=%0d ny=%0d", $time,
                             e.hit, e.cross_x, e.cross_y, e.norm_x, e.norm_y);
                    $display("%0t:          got hit=%0d x=%0d y=%0d nx=%0d ny=%0d", $time,
                             o_hit, o_cross_x, o_cross_y, o_norm_x, o_norm_y);
                    n_fail++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either channel
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog expired");
            $display("FAIL edge_plane_crossing_top");
            $finish;
        end
    end

    task automatic send_edge(t_edge e);
        int n;
        if (!quiet && $urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 8);
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_a_x <= e.a_x; i_a_y <= e.a_y; i_a_z <= e.a_z; i_a_nx <= e.a_nx; i_a_ny <= e.a_ny;
        i_b_x <= e.b_x; i_b_y <= e.b_y; i_b_z <= e.b_z; i_b_nx <= e.b_nx; i_b_ny <= e.b_ny;
        do @(posedge i_clk); while (o_stall);
        pending_q.insert(pending_q.size(), cross_of(e));
        n_sent++;
        if (pending_q[$].hit) n_hits++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic set_plane(logic signed [31:0] h);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= h;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        plane_h = h;
    endtask

    function automatic logic signed [15:0] rand_n();
        case ($urandom_range(0, 5))
            0:       return 16'($urandom);
            1:       return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    // heights kept near the plane most of the time so hits are common
    function automatic t_edge rand_edge();
        t_edge e;
        e.a_x = $urandom; e.a_y = $urandom; e.b_x = $urandom; e.b_y = $urandom;
        if ($urandom_range(0, 3) == 0) begin
            e.a_z = $urandom; e.b_z = $urandom;
        end else begin
            e.a_z = plane_h + $signed($urandom_range(0, 2000000)) - 1000000;
            e.b_z = plane_h + $signed($urandom_range(0, 2000000)) - 1000000;
            if ($urandom_range(0, 15) == 0) e.b_z = e.a_z;
            if ($urandom_range(0, 15) == 0) e.a_z = plane_h;
        end
        e.a_nx = rand_n(); e.a_ny = rand_n(); e.b_nx = rand_n(); e.b_ny = rand_n();
        if ($urandom_range(0, 15) == 0) begin
            e.b_nx = -e.a_nx; e.b_ny = -e.a_ny;
        end
        return e;
    endfunction

    task automatic test_directed();
        t_edge e;
        e = '{a_x: 32'sh0001_0000, a_y: -32'sh0002_0000, a_z: 32'sh0001_0000,
              b_x: 32'sh0003_0000, b_y: 32'sh0004_0000, b_z: -32'sh0001_0000,
              a_nx: 16'sd16384, a_ny: 0, b_nx: 0, b_ny: 16'sd16384};
        send_edge(e);
        e.a_z = 32'sh0002_0000; e.b_z = 32'sh0001_0000; send_edge(e);   // both above
        e.a_z = -32'sh0002_0000; e.b_z = -32'sh0001_0000; send_edge(e); // both below
        e.a_z = 0; e.b_z = 0; send_edge(e);                              // level on plane
        e.a_z = 0; e.b_z = 32'sh0005_0000; send_edge(e);                 // plane at A
        e.a_z = -32'sh0005_0000; e.b_z = 0; send_edge(e);                // plane at B
        e.b_nx = -16'sd16384; e.a_ny = 0; e.b_ny = 0; send_edge(e);      // zero normal sum
        e = '{a_x: 32'h7fff_ffff, a_y: 32'h8000_0000, a_z: 32'h8000_0000,
              b_x: 32'h8000_0000, b_y: 32'h7fff_ffff, b_z: 32'h7fff_ffff,
              a_nx: -16'sd16384, a_ny: -16'sd16384, b_nx: -16'sd16384, b_ny: -16'sd16384};
        send_edge(e);
        e.a_z = 32'h7fff_ffff; e.b_z = 32'h8000_0000; send_edge(e);
        e.a_nx = 16'sh7fff; e.a_ny = 16'sh8000; e.b_nx = 16'sh7fff; e.b_ny = 16'sh8000;
        send_edge(e);                                                    // normals out of range
        e.a_nx = 16'sh8000; e.b_nx = 16'sh8000; e.a_ny = 16'sh0001; e.b_ny = 0;
        send_edge(e);
        e.a_z = 32'sd1; e.b_z = -32'sd1; e.a_x = 32'sd1; e.b_x = 32'sd0; send_edge(e); // tie
        e.a_nx = 16'sd3; e.a_ny = 16'sd4; e.b_nx = 0; e.b_ny = 0; send_edge(e);
        e.a_x = -1; e.a_y = -1; e.b_x = -1; e.b_y = -1; send_edge(e);
    endtask

    task automatic test_random(int count);
        repeat (count) send_edge(rand_edge());
    endtask

    // sender holds off until the pipe has emptied, then bursts again
    task automatic test_hold_off();
        drain();
        test_random(60);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        set_plane(32'h7fff_ffff);
        test_directed();
        test_random(150);
        set_plane(32'h8000_0000);
        test_random(150);
        set_plane($urandom);
        test_random(400);
        test_hold_off();
        set_plane(-32'sh0003_8000);
        test_random(400);
        set_plane(32'sh0000_4000);
        test_random(300);
        quiet = 1'b1;
        set_plane(0);
        test_directed();
        test_random(330);
        drain();
        $display("sent %0d edges (%0d crossings) over six plane heights, checked %0d results",
                 n_sent, n_hits, n_checked);
        if (n_fail == 0) begin
            $display("PASS edge_plane_crossing_top");
        end else begin
            $display("FAIL edge_plane_crossing_top");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/epc_pkg.sv
src/edge_plane_crossing_top.sv
tb/edge_plane_crossing_top_tb.sv
